### design/sgm_pkg.sv
// shared constants, field codes and controller/datapath interface types for the sobel block
package sgm_pkg;

    localparam int PIX_W        = 8;
    localparam int CFG_W        = 12;
    localparam int CFG_IDX_W    = 1;
    localparam int ROW_W        = 12;
    localparam int DRAIN_W      = 12;
    localparam int SUM_W        = 10;
    localparam int SQ_W         = 21;
    localparam int ENERGY_W     = 8;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MAX_HEIGHT    = 4096;
    localparam int MIN_DIM       = 3;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;
    localparam int ENERGY_MAX    = 255;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    // input item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef struct packed {
        logic accept;
        logic step;
        logic grad;
        logic square;
        logic sqrt_init;
        logic sqrt_step;
        logic res_root;
        logic res_zero;
        logic drain_dec;
        logic out_load;
    } sgm_cmd_t;

    typedef struct packed {
        logic in_kind;
        logic draining;
        logic emit;
        logic interior;
        logic sqrt_last;
        logic out_free;
    } sgm_sts_t;

endpackage

### design/sgm_ctrl.sv
// controller state machine sequencing each transaction through the datapath
module sgm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sgm_pkg::sgm_sts_t sts,
    output sgm_pkg::sgm_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_STEP   = 3'd1;
    localparam logic [2:0] ST_GRAD   = 3'd2;
    localparam logic [2:0] ST_SQUARE = 3'd3;
    localparam logic [2:0] ST_SUM    = 3'd4;
    localparam logic [2:0] ST_SQRT   = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    if (sts.in_kind == sgm_pkg::KIND_DRAIN) begin
                        if (sts.draining) begin
                            cmd.drain_dec = 1'b1;
                            state_next    = ST_OUT;
                        end
                    end else if (!sts.draining) begin
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP: begin
                cmd.step = 1'b1;
                if (!sts.emit) begin
                    state_next = ST_IDLE;
                end else if (sts.interior) begin
                    state_next = ST_GRAD;
                end else begin
                    cmd.res_zero = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_GRAD: begin
                cmd.grad   = 1'b1;
                state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sqrt_init = 1'b1;
                state_next    = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (sts.sqrt_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.res_root = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### design/sgm_datapath.sv
// datapath: line buffers, 3x3 window, raster counters, gradient, square root and output register
module sgm_datapath #(
    parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tuser,
    input  logic [sgm_pkg::PIX_W-1:0]        s_tdata,
    input  logic                             cfg_valid,
    input  logic [sgm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sgm_pkg::CFG_W-1:0]        cfg_data,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sgm_pkg::ENERGY_W-1:0]     m_tdata,
    output logic                             m_tlast,
    input  sgm_pkg::sgm_cmd_t                cmd,
    output sgm_pkg::sgm_sts_t                sts
);

    localparam int COL_W  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int PIX_W  = sgm_pkg::PIX_W;
    localparam int SUM_W  = sgm_pkg::SUM_W;
    localparam int SQ_W   = sgm_pkg::SQ_W;
    localparam int CFG_W  = sgm_pkg::CFG_W;
    localparam int ROW_W  = sgm_pkg::ROW_W;
    localparam int DRN_W  = sgm_pkg::DRAIN_W;
    localparam int EN_W   = sgm_pkg::ENERGY_W;
    localparam logic [SQ_W-1:0] BIT_START = SQ_W'(1) << (SQ_W - 1);

    // configuration
    logic [CFG_W-1:0] width_cfg_reg;
    logic [CFG_W-1:0] height_cfg_reg;
    logic [CFG_W-1:0] eff_w;
    logic [CFG_W-1:0] eff_h;

    // line buffers
    logic [PIX_W-1:0] line_one_mem [MAX_WIDTH];
    logic [PIX_W-1:0] line_two_mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_one_reg;
    logic [PIX_W-1:0] rd_two_reg;
    logic [PIX_W-1:0] pix_reg;

    logic [PIX_W-1:0] win_reg [9];

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [DRN_W-1:0] drain_reg;
    logic [DRN_W-1:0] drain_next;

    // arithmetic
    logic [SUM_W-1:0]   gx_pos, gx_neg, gy_pos, gy_neg;
    logic [SUM_W-1:0]   ax_reg, ay_reg;
    logic [2*SUM_W-1:0] sqx_reg, sqy_reg;
    logic [SQ_W-1:0]    rad_reg, root_reg, bit_reg;
    logic [SQ_W:0]      trial;
    logic [SQ_W-2:0]    half_root;

    logic [EN_W-1:0] res_energy_reg;
    logic            res_last_reg;
    logic            m_tvalid_reg;
    logic [EN_W-1:0] m_tdata_reg;
    logic            m_tlast_reg;

    always_comb begin
        if (width_cfg_reg < CFG_W'(sgm_pkg::MIN_DIM)) begin
            eff_w = CFG_W'(sgm_pkg::MIN_DIM);
        end else if (32'(width_cfg_reg) > MAX_WIDTH) begin
            eff_w = CFG_W'(MAX_WIDTH);
        end else begin
            eff_w = width_cfg_reg;
        end
        if (height_cfg_reg < CFG_W'(sgm_pkg::MIN_DIM)) begin
            eff_h = CFG_W'(sgm_pkg::MIN_DIM);
        end else if (32'(height_cfg_reg) > sgm_pkg::MAX_HEIGHT) begin
            eff_h = CFG_W'(sgm_pkg::MAX_HEIGHT);
        end else begin
            eff_h = height_cfg_reg;
        end
    end

    // raster position update, counters hold the position of the incoming pixel
    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        if (cmd.step) begin
            if (32'(col_reg) + 32'd1 >= 32'(eff_w)) begin
                col_next = '0;
                if (32'(row_reg) + 32'd1 >= 32'(eff_h)) begin
                    row_next   = '0;
                    drain_next = DRN_W'(32'(eff_w) + 32'd1);
                end else begin
                    row_next = row_reg + ROW_W'(1);
                end
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end else if (cmd.drain_dec) begin
            drain_next = drain_reg - DRN_W'(1);
        end
    end

    assign sts.in_kind  = s_tuser;
    assign sts.draining = (drain_reg != '0);
    assign sts.emit     = (row_reg >= ROW_W'(2)) ||
                          (row_reg == ROW_W'(1) && col_reg >= COL_W'(1));
    assign sts.interior = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2)) &&
                          (32'(col_reg) < 32'(eff_w)) && (row_reg < eff_h);
    assign sts.sqrt_last = (bit_reg == SQ_W'(1));
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    // gradient halves from the window, each an unsigned weighted column or row sum
    assign gx_pos = SUM_W'(win_reg[2]) + {1'b0, win_reg[5], 1'b0} + SUM_W'(win_reg[8]);
    assign gx_neg = SUM_W'(win_reg[0]) + {1'b0, win_reg[3], 1'b0} + SUM_W'(win_reg[6]);
    assign gy_pos = SUM_W'(win_reg[0]) + {1'b0, win_reg[1], 1'b0} + SUM_W'(win_reg[2]);
    assign gy_neg = SUM_W'(win_reg[6]) + {1'b0, win_reg[7], 1'b0} + SUM_W'(win_reg[8]);

    assign trial     = {1'b0, root_reg} + {1'b0, bit_reg};
    assign half_root = root_reg[SQ_W-1:1];

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rd_one_reg <= line_one_mem[col_reg];
            rd_two_reg <= line_two_mem[col_reg];
        end
        if (cmd.step) begin
            line_one_mem[col_reg] <= pix_reg;
            line_two_mem[col_reg] <= rd_one_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= CFG_W'(sgm_pkg::WIDTH_RESET);
            height_cfg_reg <= CFG_W'(sgm_pkg::HEIGHT_RESET);
            col_reg        <= '0;
            row_reg        <= '0;
            drain_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    sgm_pkg::CFG_WIDTH:  width_cfg_reg  <= cfg_data;
                    sgm_pkg::CFG_HEIGHT: height_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end
            col_reg   <= col_next;
            row_reg   <= row_next;
            drain_reg <= drain_next;
            if (cmd.step) begin
                for (int i = 0; i < 3; i++) begin
                    win_reg[i*3]   <= win_reg[i*3+1];
                    win_reg[i*3+1] <= win_reg[i*3+2];
                end
                win_reg[2] <= rd_two_reg;
                win_reg[5] <= rd_one_reg;
                win_reg[8] <= pix_reg;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pix_reg <= s_tdata;
        end
        if (cmd.grad) begin
            ax_reg <= (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
            ay_reg <= (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
        end
        if (cmd.square) begin
            sqx_reg <= ax_reg * ax_reg;
            sqy_reg <= ay_reg * ay_reg;
        end
        if (cmd.sqrt_init) begin
            rad_reg  <= SQ_W'(sqx_reg) + SQ_W'(sqy_reg);
            root_reg <= '0;
            bit_reg  <= BIT_START;
        end else if (cmd.sqrt_step) begin
            // one result bit per cycle, restoring form
            if ({1'b0, rad_reg} >= trial) begin
                rad_reg  <= rad_reg - trial[SQ_W-1:0];
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.res_root) begin
            res_energy_reg <= (32'(half_root) > sgm_pkg::ENERGY_MAX) ?
                              EN_W'(sgm_pkg::ENERGY_MAX) : half_root[EN_W-1:0];
            res_last_reg   <= 1'b0;
        end else if (cmd.res_zero) begin
            res_energy_reg <= '0;
            res_last_reg   <= 1'b0;
        end else if (cmd.drain_dec) begin
            res_energy_reg <= '0;
            res_last_reg   <= (drain_reg == DRN_W'(1));
        end
        if (cmd.out_load) begin
            m_tdata_reg <= res_energy_reg;
            m_tlast_reg <= res_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### design/sobel_gradient_magnitude.sv
// top level of the streaming 3x3 sobel gradient magnitude block
//
// channel  direction  signals                                    contents
// s_       in         s_tvalid s_tready s_tdata s_tuser          pixel or drain tick
// m_       out        m_tvalid m_tready m_tdata m_tlast          energy, last of frame
// cfg_     in         cfg_valid cfg_ready cfg_index cfg_data     register writes
//
// an interior pixel runs the step, gradient, square, sum, 11-step square root, finish and
// output states; a border pixel goes from step to output, a drain tick from idle to output
// results come from an output register, so a new transaction is taken while one waits
// a stalled m_ side holds the block in its output state only when a second result is ready
// aresetn is synchronous; line buffers are not cleared and need no clearing pass
module sobel_gradient_magnitude #(
    parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sgm_pkg::PIX_W-1:0]     s_tdata,   // brightness
    input  logic                          s_tuser,   // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sgm_pkg::ENERGY_W-1:0]  m_tdata,   // energy
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sgm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sgm_pkg::CFG_W-1:0]     cfg_data
);

    sgm_pkg::sgm_cmd_t cmd;
    sgm_pkg::sgm_sts_t sts;

    assign cfg_ready = 1'b1;

    sgm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sgm_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

    // output register is never overwritten while a result waits
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a waiting result");

    // square root always runs its full number of steps
    a_sqrt_len: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sqrt_init |-> ##12 cmd.res_root)
        else $error("square root step count wrong");

    // an accepted pixel keeps the input closed while it is processed
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == sgm_pkg::KIND_PIXEL && !sts.draining)
        |=> !s_tready)
        else $error("input taken while a pixel is in work");

    // the final result of a frame is a border zero
    a_last_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata == '0))
        else $error("last of frame with nonzero energy");

endmodule

### dv/sobel_gradient_magnitude_checker.sv
`timescale 1ns / 1ps
// checker for the sobel block: predicts energies from observed transactions and compares results
module sobel_gradient_magnitude_checker
    import sgm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [PIX_W-1:0]     s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [ENERGY_W-1:0]  m_tdata,
    input  logic                 m_tlast,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   queued_results,
    output int                   mismatches
);

    typedef struct {
        logic [ENERGY_W-1:0] energy;
        logic                last;
    } energy_result_t;

    energy_result_t energy_queue[$];

    logic [PIX_W-1:0]   row_up1 [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]   row_up2 [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]   win [9];
    logic [10:0]        col_pos;
    logic [ROW_W-1:0]   row_pos;
    logic [DRAIN_W-1:0] drain_left;
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;

    initial begin
        foreach (row_up1[i]) begin
            row_up1[i] = '0;
            row_up2[i] = '0;
        end
    end

    // largest root whose square fits, built one bit at a time
    function automatic int floor_sqrt(input int value);
        int root;
        int b;
        int trial;
        root = 0;
        for (b = 10; b >= 0; b--) begin
            trial = root + (1 << b);
            if (trial * trial <= value) root = trial;
        end
        return root;
    endfunction

    function automatic logic [ENERGY_W-1:0] window_energy();
        int p [9];
        int gx;
        int gy;
        int half;
        foreach (p[i]) p[i] = win[i];
        gx = (p[2] + 2 * p[5] + p[8]) - (p[0] + 2 * p[3] + p[6]);
        gy = (p[0] + 2 * p[1] + p[2]) - (p[6] + 2 * p[7] + p[8]);
        half = floor_sqrt(gx * gx + gy * gy) / 2;
        if (half > ENERGY_MAX) half = ENERGY_MAX;
        return half[ENERGY_W-1:0];
    endfunction

    function void predict_energy(input logic kind, input logic [PIX_W-1:0] pix);
        int w;
        int h;
        int c;
        int r;
        int i;
        logic emit;
        energy_result_t res;
        w = width_reg;
        h = height_reg;
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
        if (h < MIN_DIM) h = MIN_DIM;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        res.energy = '0;
        res.last = 1'b0;

        if (kind == KIND_DRAIN) begin
            // a tick with nothing left to drain does nothing
            if (drain_left != 0) begin
                drain_left = drain_left - 1'b1;
                res.last = (drain_left == 0);
                energy_queue.push_back(res);
            end
            return;
        end
        // pixels are dropped until the previous frame has drained
        if (drain_left != 0) return;

        c = col_pos;
        r = row_pos;
        for (i = 0; i < 3; i++) begin
            win[3 * i]     = win[3 * i + 1];
            win[3 * i + 1] = win[3 * i + 2];
        end
        win[2] = row_up2[c];
        win[5] = row_up1[c];
        win[8] = pix;
        row_up2[c] = row_up1[c];
        row_up1[c] = pix;

        emit = (r >= 2) || (r == 1 && c >= 1);
        if (r >= 2 && c >= 2 && c < w && r < h) res.energy = window_energy();

        if (c + 1 >= w) begin
            col_pos = '0;
            if (r + 1 >= h) begin
                row_pos = '0;
                drain_left = DRAIN_W'(w + 1);
            end else begin
                row_pos = ROW_W'(r + 1);
            end
        end else begin
            col_pos = 11'(c + 1);
        end

        if (emit) energy_queue.push_back(res);
    endfunction

    always @(posedge aclk) begin
        energy_result_t want;
        if (!aresetn) begin
            width_reg  = CFG_W'(WIDTH_RESET);
            height_reg = CFG_W'(HEIGHT_RESET);
            foreach (win[i]) win[i] = '0;
            col_pos    = '0;
            row_pos    = '0;
            drain_left = '0;
            mismatches = 0;
            energy_queue.delete();
        end else begin
            // a result never leaves in the edge that takes its pixel, so pop before push
            if (m_tvalid && m_tready) begin
                if (energy_queue.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual energy %0d last %0d",
                             $time, m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    want = energy_queue.pop_front();
                    if (m_tdata !== want.energy) begin
                        $display("%0t: energy mismatch, expected %0d, actual %0d",
                                 $time, want.energy, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: last-of-frame mismatch, expected %0d, actual %0d",
                                 $time, want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_WIDTH) width_reg = cfg_data;
                else height_reg = cfg_data;
            end
            if (s_tvalid && s_tready) predict_energy(s_tuser, s_tdata);
        end
        queued_results <= energy_queue.size();
    end

endmodule

### dv/sobel_gradient_magnitude_tb.sv
`timescale 1ns / 1ps
// testbench top for the sobel block: frame stimulus, register writes, flow control and verdict
module sobel_gradient_magnitude_tb;
    import sgm_pkg::*;

    localparam int STALL_LIMIT     = 4000;
    localparam int PRESSURE_CYCLES = 400;
    localparam int RANDOM_ITEMS    = 850;
    localparam int SETTLE_CYCLES   = 20;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [PIX_W-1:0]     s_tdata   = '0;
    logic                 s_tuser   = KIND_PIXEL;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [ENERGY_W-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_WIDTH;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int queued_results;
    int mismatches;
    int idle_cycles   = 0;
    int counted_items = 0;
    bit pressure_req  = 1'b0;
    bit steady_send   = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sobel_gradient_magnitude dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sobel_gradient_magnitude_checker energy_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .queued_results (queued_results),
        .mismatches     (mismatches)
    );

    // watchdog: too long without any transaction ends the run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("** sobel_gradient_magnitude: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PIX_W-1:0] pick_brightness();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 2) return '0;
        if (roll < 4) return '1;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    // receiver flow control, with one long hold-off on request
    initial begin : result_sink
        int span;
        @(posedge aclk);
        forever begin
            if (pressure_req) begin
                pressure_req = 1'b0;
                m_tready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge aclk);
            end
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (span) @(posedge aclk);
            span = pick_gap();
            if (span != 0) begin
                m_tready <= 1'b0;
                repeat (span) @(posedge aclk);
            end
        end
    end

    task automatic send_item(input logic kind, input logic [PIX_W-1:0] value);
        int gap;
        gap = steady_send ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
    endtask

    // wait until every result is out and the block has finished any silent item
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (queued_results != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reconfigure(input int width_val, input int height_val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_data  <= CFG_W'(width_val);
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= CFG_W'(height_val);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_frame(input int width_val, input int height_val, input bit noisy);
        int cols;
        int rows;
        int n;
        cols = (width_val < MIN_DIM) ? MIN_DIM :
               (width_val > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_val;
        rows = (height_val < MIN_DIM) ? MIN_DIM :
               (height_val > MAX_HEIGHT) ? MAX_HEIGHT : height_val;
        reconfigure(width_val, height_val);
        for (n = 0; n < cols * rows; n++) begin
            // stray drain tick in mid frame
            if (noisy && $urandom_range(0, 29) == 0) send_item(KIND_DRAIN, pick_brightness());
            send_item(KIND_PIXEL, pick_brightness());
        end
        for (n = 0; n <= cols; n++) begin
            // pixel that arrives while the frame drains
            if (noisy && $urandom_range(0, 9) == 0) send_item(KIND_PIXEL, pick_brightness());
            send_item(KIND_DRAIN, pick_brightness());
        end
        if (noisy && $urandom_range(0, 3) == 0) send_item(KIND_DRAIN, pick_brightness());
        counted_items += cols * rows + cols + 1;
    endtask

    initial begin : stimulus
        int random_start;
        int frame_no;
        int w;
        int h;
        int r;
        int c;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: sizes below the minimum, a vertical edge strong enough to clamp,
        // and ticks or pixels that must be ignored
        reconfigure(1, 2);
        send_item(KIND_DRAIN, 8'hFF);
        for (r = 0; r < 3; r++) begin
            for (c = 0; c < 3; c++) send_item(KIND_PIXEL, (c == 2) ? 8'hFF : 8'h00);
        end
        send_item(KIND_PIXEL, 8'hAA);
        repeat (4) send_item(KIND_DRAIN, 8'h00);
        send_item(KIND_DRAIN, 8'h55);

        // a wide short frame, then a tall one from a zero width
        run_frame(64, 3, 1'b0);
        run_frame(0, 40, 1'b0);

        random_start = counted_items;
        frame_no = 0;
        while (counted_items - random_start < RANDOM_ITEMS) begin
            steady_send = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 19);
            w = (r < 2) ? $urandom_range(0, 2) : (r < 3) ? $urandom_range(17, 40) :
                $urandom_range(3, 16);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
            if (frame_no == 2) begin
                // receiver holds off while this frame streams in
                w = 12;
                h = 8;
                pressure_req = 1'b1;
            end
            run_frame(w, h, 1'b1);
            frame_no++;
        end

        settle();
        if (mismatches == 0) begin
            $display("** sobel_gradient_magnitude: PASSED **");
        end else begin
            $display("** sobel_gradient_magnitude: FAILED **");
        end
        $finish;
    end

endmodule
